// ===== rtl/i2c_eeprom_byte_master_core_defines.svh =====
// Assertion macros for the I2C EEPROM byte master core.
`ifndef I2C_EEPROM_BYTE_MASTER_CORE_DEFINES_SVH
`define I2C_EEPROM_BYTE_MASTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CEBM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define I2CEBM_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define I2CEBM_ASSERT(name, prop, msg)
`define I2CEBM_ASSERT_NEVER(name, expr, msg)
`endif

`endif

// ===== rtl/i2cebm_pkg.sv =====
// Types, step codes and helpers shared by the I2C EEPROM byte master.
package i2cebm_pkg;

  localparam int unsigned StepW   = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [StepW-1:0] ST_IDLE   = 4'd0;
  localparam logic [StepW-1:0] ST_START1 = 4'd1;
  localparam logic [StepW-1:0] ST_SELW   = 4'd2;
  localparam logic [StepW-1:0] ST_ADDR   = 4'd3;
  localparam logic [StepW-1:0] ST_DATA   = 4'd4;
  localparam logic [StepW-1:0] ST_START2 = 4'd5;
  localparam logic [StepW-1:0] ST_SELR   = 4'd6;
  localparam logic [StepW-1:0] ST_READ   = 4'd7;
  localparam logic [StepW-1:0] ST_STOP   = 4'd8;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_DEVICE_ADDRESS = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_PHASE_TICKS    = 1'd1;

  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd80;
  localparam logic [7:0] PHASE_TICKS_RST    = 8'd15;
  localparam logic [3:0] BITS_PER_BYTE      = 4'd8;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] mem_address;
    logic [7:0] write_data;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_listen;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
  } out_item_t;

  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic [1:0]       line_phase;
    logic [7:0]       tick_count;
    logic [3:0]       bit_index;
    logic [7:0]       shift_byte;
    logic             is_read;
    logic [7:0]       held_address;
    logic [7:0]       held_data;
  } seq_state_t;

  function automatic logic [7:0] load_byte(logic [StepW-1:0] step, logic [6:0] dev,
                                           logic [7:0] addr, logic [7:0] data);
    logic [7:0] val;
    case (step)
      ST_SELW: val = {dev, 1'b0};
      ST_SELR: val = {dev, 1'b1};
      ST_ADDR: val = addr;
      default: val = data;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/i2cebm_in_if.sv =====
// Valid/ready channel carrying one bus tick request.
interface i2cebm_in_if
  import i2cebm_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/i2cebm_out_if.sv =====
// Valid/ready channel carrying one line result per tick.
interface i2cebm_out_if
  import i2cebm_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/i2c_eeprom_byte_master_core.sv =====
// Top level of the I2C EEPROM byte master: tick channel, configuration and result register.
// Each transaction on the input channel is one timing tick of the bus sequencer and yields
// exactly one result transaction with the SCL/SDA levels, busy, done and the read byte.
// A tick is taken every clock while the output is taken: it is held in the input register,
// and the sequencer state and the result register update together as it moves on, so a
// result is offered from the result register, and one tick per cycle flows through while the
// output is taken.
// A write runs start, select-write, address, data, stop; a read adds a repeated start,
// select-read, eight data bits and a master ACK before stop. Each line phase lasts
// phase_ticks ticks (zero counts as one). Configuration writes take effect at once.
`include "i2c_eeprom_byte_master_core_defines.svh"

module i2c_eeprom_byte_master_core
  import i2cebm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  i2cebm_in_if.sink          in_i,
  i2cebm_out_if.source       out_o
);

  cfg_t       cfg_q, cfg_d;
  seq_state_t state_q, state_d, state_nx;
  logic       s1_valid_q, s1_valid_d;
  in_item_t   s1_item_q;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_item_q, out_item_d;
  logic       advance;
  logic       in_ready;

  assign advance  = !out_valid_q || out_o.ready;
  assign in_ready = !s1_valid_q || advance;

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  i2cebm_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .item_i  (s1_item_q),
    .state_o (state_nx),
    .res_o   (out_item_d)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEVICE_ADDRESS: cfg_d.device_address = cfg_data_i[6:0];
        REG_PHASE_TICKS:    cfg_d.phase_ticks    = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  assign s1_valid_d  = in_ready ? in_i.valid : s1_valid_q;
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;
  assign state_d     = (s1_valid_q && advance) ? state_nx : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{device_address: DEVICE_ADDRESS_RST, phase_ticks: PHASE_TICKS_RST};
      state_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      state_q     <= state_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_item_q <= in_i.payload;
    end
    if (advance && s1_valid_q) begin
      out_item_q <= out_item_d;
    end
  end

  `I2CEBM_ASSERT(a_listen_released, out_valid_q && out_item_q.sda_listen |-> out_item_q.sda_level, "SDA driven low while listening")
  `I2CEBM_ASSERT(a_done_busy, out_valid_q && out_item_q.done_res |-> out_item_q.busy_res, "done without busy")
  `I2CEBM_ASSERT(a_read_byte_done, out_valid_q && (out_item_q.read_byte != 8'd0) |-> out_item_q.done_res, "read byte outside done")
  `I2CEBM_ASSERT_NEVER(a_step_legal, state_q.step > ST_STOP, "sequencer step out of range")
  `I2CEBM_ASSERT(a_idle_tick_stays, s1_valid_q && advance && (state_q.step == ST_IDLE) && (s1_item_q.operation == OP_TICK) |=> state_q.step == ST_IDLE, "idle tick left idle")

endmodule

// ===== rtl/i2cebm_step.sv =====
// Combinational sequencer step: line levels and next state for one tick.
module i2cebm_step
  import i2cebm_pkg::*;
(
  input  cfg_t       cfg_i,
  input  seq_state_t state_i,
  input  in_item_t   item_i,
  output seq_state_t state_o,
  output out_item_t  res_o
);

  seq_state_t       st;
  out_item_t        res;
  logic [7:0]       pt;
  logic [8:0]       tick_inc;
  logic             is_start;
  logic             is_byte;
  logic [1:0]       last_phase;
  logic             do_enter;
  logic [StepW-1:0] nxt;

  always_comb begin
    st         = state_i;
    res        = '0;
    res.scl_level = 1'b1;
    res.sda_level = 1'b1;
    pt         = (cfg_i.phase_ticks == 8'd0) ? 8'd1 : cfg_i.phase_ticks;
    tick_inc   = {1'b0, state_i.tick_count} + 9'd1;
    is_start   = 1'b0;
    is_byte    = 1'b0;
    last_phase = 2'd2;
    do_enter   = 1'b0;
    nxt        = ST_IDLE;

    if (st.step > ST_STOP) begin
      st.step = ST_IDLE;
    end
    if (st.step == ST_IDLE &&
        (item_i.operation == OP_WRITE || item_i.operation == OP_READ)) begin
      st.is_read      = (item_i.operation == OP_READ);
      st.held_address = item_i.mem_address;
      st.held_data    = item_i.write_data;
      st.tick_count   = 8'd0;
      st.shift_byte   = 8'd0;
      st.step         = ST_START1;
      st.line_phase   = 2'd0;
      st.bit_index    = 4'd0;
    end

    if (st.step != ST_IDLE) begin
      res.busy_res = 1'b1;
      case (st.step)
        ST_START1, ST_START2: begin
          res.scl_level = (st.line_phase == 2'd1) || (st.line_phase == 2'd2);
          res.sda_level = (st.line_phase < 2'd2);
        end
        ST_STOP: begin
          res.scl_level = (st.line_phase != 2'd0);
          res.sda_level = (st.line_phase == 2'd2);
        end
        ST_READ: begin
          res.scl_level = (st.line_phase == 2'd1);
          if (st.bit_index < BITS_PER_BYTE) begin
            res.sda_listen = 1'b1;
          end else begin
            res.sda_level = 1'b0;
          end
        end
        default: begin
          res.scl_level = (st.line_phase == 2'd1);
          if (st.bit_index < BITS_PER_BYTE) begin
            res.sda_level = st.shift_byte[7];
          end else begin
            res.sda_listen = 1'b1;
          end
        end
      endcase

      tick_inc = {1'b0, st.tick_count} + 9'd1;
      if (tick_inc < {1'b0, pt}) begin
        st.tick_count = tick_inc[7:0];
      end else begin
        st.tick_count = 8'd0;
        is_start = st.step inside {ST_START1, ST_START2};
        is_byte  = st.step inside {ST_SELW, ST_ADDR, ST_DATA, ST_SELR};
        last_phase = is_start ? 2'd3 : 2'd2;

        if (st.step == ST_READ && st.bit_index < BITS_PER_BYTE && st.line_phase == 2'd1) begin
          st.shift_byte = {st.shift_byte[6:0], item_i.sda_sample};
        end
        if (is_byte && st.bit_index == BITS_PER_BYTE && st.line_phase == 2'd1) begin
          st.shift_byte = {7'd0, item_i.sda_sample};
        end

        if (st.line_phase < last_phase) begin
          st.line_phase = st.line_phase + 2'd1;
        end else begin
          st.line_phase = 2'd0;
          case (st.step)
            ST_START1: begin
              do_enter = 1'b1;
              nxt      = ST_SELW;
            end
            ST_START2: begin
              do_enter = 1'b1;
              nxt      = ST_SELR;
            end
            ST_STOP: begin
              st.step       = ST_IDLE;
              res.done_res  = 1'b1;
              res.read_byte = st.is_read ? st.shift_byte : 8'd0;
            end
            ST_READ: begin
              if (st.bit_index < BITS_PER_BYTE) begin
                st.bit_index = st.bit_index + 4'd1;
              end else begin
                do_enter = 1'b1;
                nxt      = ST_STOP;
              end
            end
            default: begin
              do_enter = 1'b1;
              if (st.bit_index < BITS_PER_BYTE) begin
                do_enter      = 1'b0;
                st.shift_byte = {st.shift_byte[6:0], 1'b0};
                st.bit_index  = st.bit_index + 4'd1;
              end else if (!st.shift_byte[0]) begin
                case (st.step)
                  ST_SELW: nxt = ST_ADDR;
                  ST_ADDR: nxt = st.is_read ? ST_START2 : ST_DATA;
                  ST_DATA: nxt = ST_STOP;
                  default: nxt = ST_READ;
                endcase
              end else begin
                case (st.step)
                  ST_SELW: nxt = ST_START1;
                  ST_SELR: nxt = ST_START2;
                  default: nxt = st.step;
                endcase
              end
            end
          endcase

          if (do_enter) begin
            st.step       = nxt;
            st.line_phase = 2'd0;
            st.bit_index  = 4'd0;
            if (nxt inside {ST_SELW, ST_SELR, ST_ADDR, ST_DATA}) begin
              st.shift_byte = load_byte(nxt, cfg_i.device_address, st.held_address,
                                        st.held_data);
            end else if (nxt == ST_READ) begin
              st.shift_byte = 8'd0;
            end
          end
        end
      end
    end

    state_o = st;
    res_o   = res;
  end

endmodule
